@@ rtl/tmh_pkg.sv @@
// tmh_pkg: shared codes, field widths and the controller/datapath
// command and status structs for the timer min-heap unit
// no dependencies
`timescale 1ns / 1ps

package tmh_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 10;
  localparam int TO_W     = 24;
  localparam int KIND_W   = 2;
  localparam int WAIT_W   = 25;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADJUST = 3'd1;
  localparam logic [OP_W-1:0] OP_FIRE   = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  localparam logic [WAIT_W-1:0] WAIT_EMPTY = 25'h1FF_FFFF;
  localparam logic [TO_W-1:0]   WAIT_CLAMP = 24'hFF_FFFF;

  // which result the datapath builds on an emit
  localparam logic [2:0] EM_OK     = 3'd0;
  localparam logic [2:0] EM_FULL   = 3'd1;
  localparam logic [2:0] EM_ABSENT = 3'd2;
  localparam logic [2:0] EM_FIRE   = 3'd3;
  localparam logic [2:0] EM_PEND   = 3'd4;
  localparam logic [2:0] EM_WAIT   = 3'd5;

  typedef struct packed {
    logic       take_in;
    logic       init_wr;
    logic       tick;
    logic       clear;
    logic       rd_slot;
    logic       rd_lk;
    logic       ins_begin;
    logic       rst_begin;
    logic       rm_begin;
    logic       rm_load;
    logic       sd_rd_left;
    logic       sd_rd_right;
    logic       sd_move;
    logic       su_rd;
    logic       su_move;
    logic       fin;
    logic       due_rd;
    logic       due_take;
    logic       pend_clr;
    logic       emit;
    logic [2:0] emit_sel;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_fire;
    logic            init_done;
    logic            id_ok;
    logic            present;
    logic            full;
    logic            has_left;
    logic            sd_stop;
    logic            moved;
    logic            at_root;
    logic            su_stop;
    logic            rm_sift;
    logic            due_now;
    logic            pend;
    logic            out_free;
  } stat_t;

endpackage

@@ rtl/tmh_req_if.sv @@
// tmh_req_if: request channel (operation, timer id, timeout)
// depends on tmh_pkg
`timescale 1ns / 1ps

interface tmh_req_if;
  logic                        valid;
  logic                        ready;
  logic [tmh_pkg::OP_W-1:0]    operation;
  logic [tmh_pkg::ID_W-1:0]    timer_id;
  logic [tmh_pkg::TO_W-1:0]    timeout_ms;

  modport source (output valid, operation, timer_id, timeout_ms, input ready);
  modport sink   (input valid, operation, timer_id, timeout_ms, output ready);
endinterface

@@ rtl/tmh_rsp_if.sv @@
// tmh_rsp_if: result channel (kind, expired id, wait, status, last)
// depends on tmh_pkg
`timescale 1ns / 1ps

interface tmh_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tmh_pkg::KIND_W-1:0]       kind;
  logic [tmh_pkg::ID_W-1:0]         expired_id;
  logic signed [tmh_pkg::WAIT_W-1:0] wait_ms;
  logic [tmh_pkg::STATUS_W-1:0]     status;
  logic                             last;

  modport source (output valid, kind, expired_id, wait_ms, status, last, input ready);
  modport sink   (input valid, kind, expired_id, wait_ms, status, last, output ready);
endinterface

@@ rtl/timer_min_heap_unit.sv @@
// timer_min_heap_unit: top level of the timer queue, a controller plus datapath
// depends on tmh_pkg, tmh_req_if, tmh_rsp_if, tmh_ctrl, tmh_dp
`timescale 1ns / 1ps

// Timer queue held as a binary min-heap of (expiry, id) in a CAPACITY-deep
// memory pair, with an ID_SPACE-deep id-to-slot map and a saturating
// TIME_BITS millisecond clock. One request item is taken at a time; it
// produces zero or more result items, the final one marked by last (a tick
// with nothing due produces none). After reset the block sweeps all ID_SPACE
// entries of the slot map (1024 by default) before it takes its first item.
// An add or adjust first looks up the id's slot, then sifts the entry down
// or up the heap, writes it back and replies; a fire looks up the id,
// replies and removes the entry. Each due timer emitted by tick or query
// adds a removal with its own sift. Every sift step walks through the
// single read port of the heap memory. Results wait in an output register,
// so a slow result consumer only stalls the block while a result is being
// produced.
module timer_min_heap_unit #(
  parameter int CAPACITY  = 32,
  parameter int ID_SPACE  = 1024,
  parameter int TIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  tmh_req_if.sink   req,
  tmh_rsp_if.source rsp
);

  // commands down to the datapath, status back up
  tmh_pkg::cmd_t  cmd;
  tmh_pkg::stat_t stat;

  tmh_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  tmh_dp #(
    .CAPACITY  (CAPACITY),
    .ID_SPACE  (ID_SPACE),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

  // a result is only built when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result built while output register busy");

  // the heap memory sees at most one write per cycle
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sd_move, cmd.su_move, cmd.fin}))
    else $error("conflicting heap writes");

  // no item is taken during the map sweep
  a_no_take_init: assert property (@(posedge clk) disable iff (rst)
    cmd.init_wr |-> !req.ready)
    else $error("item taken during map sweep");

  // a sweep step is never mixed with heap work
  a_init_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.init_wr |-> !(cmd.rd_slot || cmd.emit || cmd.fin))
    else $error("map sweep overlaps an operation");

endmodule

@@ rtl/tmh_ctrl.sv @@
// tmh_ctrl: sequencer for lookup, insert, restart, remove and the due sweep
// depends on tmh_pkg; drives the datapath through cmd_t, reads stat_t
`timescale 1ns / 1ps

module tmh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  tmh_pkg::stat_t stat,
  output tmh_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_LK1   = 4'd3;
  localparam logic [3:0] S_LK2   = 4'd4;
  localparam logic [3:0] S_RM    = 4'd5;
  localparam logic [3:0] S_SD_L  = 4'd6;
  localparam logic [3:0] S_SD_R  = 4'd7;
  localparam logic [3:0] S_SD_C  = 4'd8;
  localparam logic [3:0] S_SU_R  = 4'd9;
  localparam logic [3:0] S_SU_C  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_REPLY = 4'd12;
  localparam logic [3:0] S_DUE   = 4'd13;
  localparam logic [3:0] S_DUE2  = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] after;

  // where a finished sift or removal returns to
  always_comb begin
    case (stat.op)
      tmh_pkg::OP_ADD, tmh_pkg::OP_ADJUST: after = S_REPLY;
      tmh_pkg::OP_FIRE:                    after = S_IDLE;
      default:                             after = S_DUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.take_in = 1'b1;
        if (stat.in_fire) state_next = S_DEC;
      end
      S_DEC: begin
        case (stat.op)
          tmh_pkg::OP_ADD, tmh_pkg::OP_ADJUST, tmh_pkg::OP_FIRE: begin
            if (!stat.id_ok) begin
              if (stat.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = tmh_pkg::EM_ABSENT;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
              end
            end else begin
              cmd.rd_slot = 1'b1;
              state_next  = S_LK1;
            end
          end
          tmh_pkg::OP_TICK: begin
            cmd.tick   = 1'b1;
            state_next = S_DUE;
          end
          tmh_pkg::OP_QUERY: state_next = S_DUE;
          default: begin
            if (stat.out_free) begin
              cmd.clear     = (stat.op == tmh_pkg::OP_CLEAR);
              cmd.emit      = 1'b1;
              cmd.emit_sel  = tmh_pkg::EM_OK;
              cmd.emit_last = 1'b1;
              state_next    = S_IDLE;
            end
          end
        endcase
      end
      S_LK1: begin
        cmd.rd_lk  = 1'b1;
        state_next = S_LK2;
      end
      S_LK2: begin
        if (stat.present && stat.op != tmh_pkg::OP_FIRE) begin
          cmd.rst_begin = 1'b1;
          state_next    = S_SD_L;
        end else if (stat.present) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = tmh_pkg::EM_FIRE;
            cmd.emit_last = 1'b1;
            cmd.rm_begin  = 1'b1;
            state_next    = S_RM;
          end
        end else if (stat.op == tmh_pkg::OP_ADD && !stat.full) begin
          cmd.ins_begin = 1'b1;
          state_next    = S_SU_R;
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = (stat.op == tmh_pkg::OP_ADD) ? tmh_pkg::EM_FULL
                                                       : tmh_pkg::EM_ABSENT;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RM: begin
        if (stat.rm_sift) begin
          cmd.rm_load = 1'b1;
          state_next  = S_SD_L;
        end else begin
          state_next = after;
        end
      end
      S_SD_L: begin
        if (stat.has_left) begin
          cmd.sd_rd_left = 1'b1;
          state_next     = S_SD_R;
        end else begin
          state_next = stat.moved ? S_FIN : S_SU_R;
        end
      end
      S_SD_R: begin
        cmd.sd_rd_right = 1'b1;
        state_next      = S_SD_C;
      end
      S_SD_C: begin
        if (stat.sd_stop) begin
          state_next = stat.moved ? S_FIN : S_SU_R;
        end else begin
          cmd.sd_move = 1'b1;
          state_next  = S_SD_L;
        end
      end
      S_SU_R: begin
        if (stat.at_root) begin
          state_next = S_FIN;
        end else begin
          cmd.su_rd  = 1'b1;
          state_next = S_SU_C;
        end
      end
      S_SU_C: begin
        if (stat.su_stop) begin
          state_next = S_FIN;
        end else begin
          cmd.su_move = 1'b1;
          state_next  = S_SU_R;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = after;
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = tmh_pkg::EM_OK;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DUE: begin
        cmd.due_rd = 1'b1;
        state_next = S_DUE2;
      end
      S_DUE2: begin
        if (stat.pend) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = tmh_pkg::EM_PEND;
            cmd.emit_last = (stat.op == tmh_pkg::OP_TICK) && !stat.due_now;
            cmd.pend_clr  = 1'b1;
          end
        end else if (stat.due_now) begin
          cmd.due_take = 1'b1;
          cmd.rm_begin = 1'b1;
          state_next   = S_RM;
        end else if (stat.op == tmh_pkg::OP_QUERY) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = tmh_pkg::EM_WAIT;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/tmh_dp.sv @@
// tmh_dp: heap memories, id-to-slot map, time counter and result register
// depends on tmh_pkg, tmh_req_if, tmh_rsp_if; obeys cmd_t from tmh_ctrl
`timescale 1ns / 1ps

module tmh_dp #(
  parameter int CAPACITY  = 32,
  parameter int ID_SPACE  = 1024,
  parameter int TIME_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  tmh_req_if.sink        req,
  tmh_rsp_if.source      rsp,
  input  tmh_pkg::cmd_t  cmd,
  output tmh_pkg::stat_t stat
);

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CW     = SLOT_W + 2;
  localparam int IDX_W  = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int SUM_W  = ((TIME_BITS > tmh_pkg::TO_W) ? TIME_BITS : tmh_pkg::TO_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // memories
  logic [TIME_BITS-1:0]      exp_mem  [CAPACITY];
  logic [tmh_pkg::ID_W-1:0]  hid_mem  [CAPACITY];
  logic [SLOT_W-1:0]         slot_mem [ID_SPACE];

  logic [tmh_pkg::OP_W-1:0]  op_q;
  logic [tmh_pkg::ID_W-1:0]  id_q;
  logic [tmh_pkg::TO_W-1:0]  to_q;
  logic [TIME_BITS-1:0]      now;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          lim;
  logic [SLOT_W-1:0]         hole;
  logic [SLOT_W-1:0]         slot_q;
  logic [TIME_BITS-1:0]      hq_exp;
  logic [tmh_pkg::ID_W-1:0]  hq_id;
  logic [TIME_BITS-1:0]      cur_exp;
  logic [tmh_pkg::ID_W-1:0]  cur_id;
  logic [TIME_BITS-1:0]      l_exp;
  logic [tmh_pkg::ID_W-1:0]  l_id;
  logic                      rvalid;
  logic                      moved;
  logic                      pend;
  logic [tmh_pkg::ID_W-1:0]  pend_id;
  logic [IDX_W-1:0]          init_cnt;

  logic                      out_valid;
  logic [tmh_pkg::KIND_W-1:0]   out_kind;
  logic [tmh_pkg::ID_W-1:0]     out_id;
  logic [tmh_pkg::WAIT_W-1:0]   out_wait;
  logic [tmh_pkg::STATUS_W-1:0] out_status;
  logic                         out_last;

  logic                      in_fire;
  logic [IDX_W-1:0]          map_addr;
  logic [CW-1:0]             c_left;
  logic [CW-1:0]             c_right;
  logic [SLOT_W-1:0]         parent;
  logic                      pick_r;
  logic [TIME_BITS-1:0]      ch_exp;
  logic [tmh_pkg::ID_W-1:0]  ch_id;
  logic [SLOT_W-1:0]         ch_idx;
  logic [SUM_W-1:0]          exp_sum;
  logic [TIME_BITS-1:0]      expiry;
  logic [TIME_BITS-1:0]      diff;
  logic [tmh_pkg::WAIT_W-1:0] wait_val;
  logic                      hrd;
  logic [SLOT_W-1:0]         hrd_addr;
  logic                      hwr;
  logic [SLOT_W-1:0]         hwr_addr;
  logic [TIME_BITS-1:0]      hwr_exp;
  logic [tmh_pkg::ID_W-1:0]  hwr_id;
  logic                      swr;
  logic [IDX_W-1:0]          swr_addr;
  logic [SLOT_W-1:0]         swr_val;

  assign in_fire   = req.valid && cmd.take_in;
  assign req.ready = cmd.take_in;

  assign map_addr = IDX_W'(id_q);
  assign c_left   = {1'b0, hole, 1'b1};
  assign c_right  = c_left + CW'(1);
  assign parent   = (hole - SLOT_W'(1)) >> 1;

  assign pick_r = rvalid && (hq_exp < l_exp);
  assign ch_exp = pick_r ? hq_exp : l_exp;
  assign ch_id  = pick_r ? hq_id  : l_id;
  assign ch_idx = pick_r ? SLOT_W'(c_right) : SLOT_W'(c_left);

  // saturating expiry
  assign exp_sum = SUM_W'(now) + SUM_W'(to_q);
  assign expiry  = (exp_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(exp_sum);

  assign diff = hq_exp - now;
  always_comb begin
    if (cnt == '0) begin
      wait_val = tmh_pkg::WAIT_EMPTY;
    end else if (64'(diff) > 64'(tmh_pkg::WAIT_CLAMP)) begin
      wait_val = tmh_pkg::WAIT_W'(tmh_pkg::WAIT_CLAMP);
    end else begin
      wait_val = tmh_pkg::WAIT_W'(diff);
    end
  end

  // heap read address
  always_comb begin
    hrd      = 1'b1;
    hrd_addr = '0;
    if (cmd.rd_lk) begin
      hrd_addr = slot_q;
    end else if (cmd.rm_begin) begin
      hrd_addr = SLOT_W'(cnt - CNT_W'(1));
    end else if (cmd.sd_rd_left) begin
      hrd_addr = SLOT_W'(c_left);
    end else if (cmd.sd_rd_right) begin
      hrd_addr = SLOT_W'(c_right);
    end else if (cmd.su_rd) begin
      hrd_addr = parent;
    end else if (cmd.due_rd) begin
      hrd_addr = '0;
    end else begin
      hrd = 1'b0;
    end
  end

  // heap and map writes
  always_comb begin
    hwr      = 1'b1;
    hwr_addr = hole;
    hwr_exp  = cur_exp;
    hwr_id   = cur_id;
    swr      = 1'b1;
    swr_addr = IDX_W'(cur_id);
    swr_val  = hole;
    if (cmd.sd_move) begin
      hwr_exp  = ch_exp;
      hwr_id   = ch_id;
      swr_addr = IDX_W'(ch_id);
    end else if (cmd.su_move) begin
      hwr_exp  = hq_exp;
      hwr_id   = hq_id;
      swr_addr = IDX_W'(hq_id);
    end else if (cmd.fin) begin
      hwr_exp  = cur_exp;
    end else begin
      hwr      = 1'b0;
      swr      = cmd.init_wr;
      swr_addr = init_cnt;
      swr_val  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (hwr) begin
      exp_mem[hwr_addr] <= hwr_exp;
      hid_mem[hwr_addr] <= hwr_id;
    end
    if (hrd) begin
      hq_exp <= exp_mem[hrd_addr];
      hq_id  <= hid_mem[hrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (swr) begin
      slot_mem[swr_addr] <= swr_val;
    end
    if (cmd.rd_slot) begin
      slot_q <= slot_mem[map_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q <= req.operation;
      id_q <= req.timer_id;
      to_q <= req.timeout_ms;
    end
    if (cmd.rd_lk) hole <= slot_q;
    if (cmd.ins_begin) begin
      hole    <= SLOT_W'(cnt);
      cur_exp <= expiry;
      cur_id  <= id_q;
    end
    if (cmd.rst_begin) begin
      cur_exp <= expiry;
      cur_id  <= id_q;
      lim     <= cnt;
    end
    if (cmd.rm_load) begin
      cur_exp <= hq_exp;
      cur_id  <= hq_id;
      lim     <= cnt;
    end
    if (cmd.sd_rd_right) begin
      l_exp  <= hq_exp;
      l_id   <= hq_id;
      rvalid <= (c_right < CW'(lim));
    end
    if (cmd.sd_move) hole <= ch_idx;
    if (cmd.su_move) hole <= parent;
    if (cmd.due_take) begin
      hole    <= '0;
      pend_id <= hq_id;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now      <= '0;
      cnt      <= '0;
      moved    <= 1'b0;
      pend     <= 1'b0;
      init_cnt <= '0;
    end else begin
      if (cmd.tick && now != TIME_MAX) now <= now + TIME_BITS'(1);
      if (cmd.clear) begin
        cnt <= '0;
      end else if (cmd.ins_begin) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.rm_begin) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.rst_begin || cmd.rm_load) begin
        moved <= 1'b0;
      end else if (cmd.sd_move) begin
        moved <= 1'b1;
      end
      if (cmd.due_take) begin
        pend <= 1'b1;
      end else if (cmd.pend_clr) begin
        pend <= 1'b0;
      end
      if (cmd.init_wr) init_cnt <= init_cnt + IDX_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind   <= tmh_pkg::KIND_STATUS;
      out_id     <= '0;
      out_wait   <= '0;
      out_status <= tmh_pkg::ST_OK;
      out_last   <= cmd.emit_last;
      case (cmd.emit_sel)
        tmh_pkg::EM_FULL:   out_status <= tmh_pkg::ST_FULL;
        tmh_pkg::EM_ABSENT: out_status <= tmh_pkg::ST_ABSENT;
        tmh_pkg::EM_FIRE: begin
          out_kind <= tmh_pkg::KIND_EXPIRE;
          out_id   <= id_q;
        end
        tmh_pkg::EM_PEND: begin
          out_kind <= tmh_pkg::KIND_EXPIRE;
          out_id   <= pend_id;
        end
        tmh_pkg::EM_WAIT: begin
          out_kind <= tmh_pkg::KIND_WAIT;
          out_wait <= wait_val;
        end
        default: out_status <= tmh_pkg::ST_OK;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_kind;
  assign rsp.expired_id = out_id;
  assign rsp.wait_ms    = out_wait;
  assign rsp.status     = out_status;
  assign rsp.last       = out_last;

  // status toward the controller
  always_comb begin
    stat.op        = op_q;
    stat.in_fire   = in_fire;
    stat.init_done = (init_cnt == IDX_W'(ID_SPACE - 1));
    stat.id_ok     = (32'(id_q) < ID_SPACE);
    stat.present   = (CNT_W'(hole) < cnt) && (hq_id == id_q);
    stat.full      = (cnt >= CNT_W'(CAPACITY));
    stat.has_left  = (c_left < CW'(lim));
    stat.sd_stop   = (cur_exp < ch_exp);
    stat.moved     = moved;
    stat.at_root   = (hole == '0);
    stat.su_stop   = (hq_exp < cur_exp);
    stat.rm_sift   = (CNT_W'(hole) < cnt);
    stat.due_now   = (cnt != '0) && (hq_exp <= now);
    stat.pend      = pend;
    stat.out_free  = !out_valid || rsp.ready;
  end

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking testbench for timer_min_heap_unit
// depends on tmh_pkg, tmh_req_if, tmh_rsp_if and the unit itself
`timescale 1ns / 1ps

module tb_top;

  localparam int HEAP_DEPTH  = 32;
  localparam int IDS         = 1024;
  localparam int WDOG_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 200;
  localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;
  // unused operation code, and a queue marker that is never sent
  localparam logic [tmh_pkg::OP_W-1:0] OP_UNUSED     = 3'd6;
  localparam logic [tmh_pkg::OP_W-1:0] OP_DRAIN_MARK = 3'd7;

  typedef struct packed {
    logic [tmh_pkg::OP_W-1:0] op;
    logic [tmh_pkg::ID_W-1:0] id;
    logic [tmh_pkg::TO_W-1:0] tmo;
  } req_item_t;

  typedef struct packed {
    logic [tmh_pkg::KIND_W-1:0]   kind;
    logic [tmh_pkg::ID_W-1:0]     id;
    logic [tmh_pkg::WAIT_W-1:0]   wait_v;
    logic [tmh_pkg::STATUS_W-1:0] status;
    logic                         last;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tmh_req_if req ();
  tmh_rsp_if rsp ();

  timer_min_heap_unit uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #6 clk = ~clk;

  // shadow of the timer queue
  logic [31:0]              sh_now;
  logic [31:0]              sh_exp [HEAP_DEPTH];
  logic [tmh_pkg::ID_W-1:0] sh_tid [HEAP_DEPTH];
  int                       sh_slot [IDS];
  bit                       sh_live [IDS];
  int                       sh_count;

  req_item_t pending_reqs[$];
  rsp_item_t expected_rsps[$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  function automatic rsp_item_t mk(logic [tmh_pkg::KIND_W-1:0] k,
                                   logic [tmh_pkg::ID_W-1:0] i,
                                   logic [tmh_pkg::WAIT_W-1:0] w,
                                   logic [tmh_pkg::STATUS_W-1:0] s);
    rsp_item_t r;
    r.kind = k; r.id = i; r.wait_v = w; r.status = s; r.last = 1'b0;
    return r;
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [31:0] e;
    logic [tmh_pkg::ID_W-1:0] t;
    e = sh_exp[a]; t = sh_tid[a];
    sh_exp[a] = sh_exp[b]; sh_tid[a] = sh_tid[b];
    sh_exp[b] = e; sh_tid[b] = t;
    sh_slot[sh_tid[a]] = a;
    sh_slot[sh_tid[b]] = b;
  endfunction

  function automatic void bubble_up(int p);
    int q;
    while (p > 0) begin
      q = (p - 1) / 2;
      if (sh_exp[q] < sh_exp[p]) break;
      swap_entries(q, p);
      p = q;
    end
  endfunction

  function automatic bit bubble_down(int start, int n);
    int p, c;
    p = start;
    c = 2 * p + 1;
    while (c < n) begin
      if (c + 1 < n && sh_exp[c+1] < sh_exp[c]) c++;
      if (sh_exp[p] < sh_exp[c]) break;
      swap_entries(p, c);
      p = c;
      c = 2 * p + 1;
    end
    return p > start;
  endfunction

  function automatic void drop_entry(int p);
    int e;
    e = sh_count - 1;
    if (p < e) begin
      swap_entries(p, e);
      if (!bubble_down(p, e)) bubble_up(p);
    end
    sh_live[sh_tid[e]] = 1'b0;
    sh_count = e;
  endfunction

  function automatic logic [31:0] expiry_at(logic [tmh_pkg::TO_W-1:0] tmo);
    logic [32:0] s;
    s = {1'b0, sh_now} + tmo;
    return s[32] ? CLOCK_MAX : s[31:0];
  endfunction

  function automatic void rearm(int id, logic [tmh_pkg::TO_W-1:0] tmo);
    int p;
    p = sh_slot[id];
    sh_exp[p] = expiry_at(tmo);
    if (!bubble_down(p, sh_count)) bubble_up(p);
  endfunction

  // removes and queues every due timer in heap order
  function automatic void pop_due(ref rsp_item_t r[$]);
    while (sh_count > 0 && sh_exp[0] <= sh_now) begin
      r.push_back(mk(tmh_pkg::KIND_EXPIRE, sh_tid[0], '0, tmh_pkg::ST_OK));
      drop_entry(0);
    end
  endfunction

  // applies one request to the shadow queue and records its results
  function automatic void predict_timer_op(req_item_t it);
    rsp_item_t r[$];
    logic [31:0] d;
    logic [tmh_pkg::WAIT_W-1:0] w;
    int id;
    id = it.id;
    case (it.op)
      tmh_pkg::OP_ADD: begin
        if (sh_live[id]) begin
          rearm(id, it.tmo);
          r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_OK));
        end else if (sh_count >= HEAP_DEPTH) begin
          r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_FULL));
        end else begin
          sh_exp[sh_count] = expiry_at(it.tmo);
          sh_tid[sh_count] = it.id;
          sh_slot[id] = sh_count;
          sh_live[id] = 1'b1;
          sh_count++;
          bubble_up(sh_count - 1);
          r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_OK));
        end
      end
      tmh_pkg::OP_ADJUST: begin
        if (sh_live[id]) begin
          rearm(id, it.tmo);
          r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_OK));
        end else begin
          r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_ABSENT));
        end
      end
      tmh_pkg::OP_FIRE: begin
        if (sh_live[id]) begin
          r.push_back(mk(tmh_pkg::KIND_EXPIRE, it.id, '0, tmh_pkg::ST_OK));
          drop_entry(sh_slot[id]);
        end else begin
          r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_ABSENT));
        end
      end
      tmh_pkg::OP_TICK: begin
        if (sh_now < CLOCK_MAX) sh_now++;
        pop_due(r);
      end
      tmh_pkg::OP_QUERY: begin
        pop_due(r);
        w = tmh_pkg::WAIT_EMPTY;
        if (sh_count > 0) begin
          d = (sh_exp[0] > sh_now) ? sh_exp[0] - sh_now : 32'd0;
          w = (d > 32'hFF_FFFF) ? {1'b0, tmh_pkg::WAIT_CLAMP} : d[tmh_pkg::WAIT_W-1:0];
        end
        r.push_back(mk(tmh_pkg::KIND_WAIT, '0, w, tmh_pkg::ST_OK));
      end
      tmh_pkg::OP_CLEAR: begin
        sh_count = 0;
        foreach (sh_live[i]) sh_live[i] = 1'b0;
        r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_OK));
      end
      default: r.push_back(mk(tmh_pkg::KIND_STATUS, '0, '0, tmh_pkg::ST_OK));
    endcase
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    foreach (r[i]) expected_rsps.push_back(r[i]);
  endfunction

  function automatic void queue_op(logic [tmh_pkg::OP_W-1:0] op,
                                   logic [tmh_pkg::ID_W-1:0] id,
                                   logic [tmh_pkg::TO_W-1:0] tmo);
    req_item_t it;
    it.op = op; it.id = id; it.tmo = tmo;
    pending_reqs.push_back(it);
  endfunction

  // driver: one item at a time, with a random gap after each
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req.ready) begin
      // keep presenting the item
    end else begin
      if (req.valid && req.ready) predict_timer_op(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && pending_reqs[0].op === OP_DRAIN_MARK) begin
        // marker item: hold off until everything expected is back
        req.valid <= 1'b0;
        if (expected_rsps.size() == 0) void'(pending_reqs.pop_front());
      end else if (send_gap == 0 && pending_reqs.size() > 0) begin
        req.valid      <= 1'b1;
        req.operation  <= pending_reqs[0].op;
        req.timer_id   <= pending_reqs[0].id;
        req.timeout_ms <= pending_reqs[0].tmo;
        send_gap       <= $urandom_range(0, 3);
      end else begin
        req.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end
    end
  end

  // monitor: random stalls on the result side, compare in order
  int recv_gap = 0;
  always @(posedge clk) begin
    rsp_item_t got, want;
    int pause;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      got.kind = rsp.kind; got.id = rsp.expired_id; got.wait_v = rsp.wait_ms;
      got.status = rsp.status; got.last = rsp.last;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d id=%0d wait=%0d status=%0d last=%0d",
                   got.kind, got.id, got.wait_v, got.status, got.last);
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected kind=%0d id=%0d wait=%0d st=%0d ",
                      "last=%0d, got kind=%0d id=%0d wait=%0d st=%0d last=%0d"},
                     want.kind, want.id, want.wait_v, want.status, want.last,
                     got.kind, got.id, got.wait_v, got.status, got.last);
        end
      end
      pause = $urandom_range(0, 3);
      recv_gap  <= pause;
      rsp.ready <= (pause == 0);
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      rsp.ready <= (recv_gap == 1);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sequence of timer operations: directed corner cases, then random traffic
  initial begin
    int op_pick, kind;
    logic [tmh_pkg::ID_W-1:0] id_pick;
    req.valid = 1'b0; req.operation = '0; req.timer_id = '0; req.timeout_ms = '0;
    rsp.ready = 1'b0;
    sh_now = '0; sh_count = 0;
    foreach (sh_live[i]) sh_live[i] = 1'b0;
    foreach (sh_slot[i]) sh_slot[i] = 0;

    // directed: empty query, absent ids, extremes of timeout and id
    queue_op(tmh_pkg::OP_QUERY, 10'd0, 24'd0);
    queue_op(tmh_pkg::OP_ADJUST, 10'd5, 24'd3);
    queue_op(tmh_pkg::OP_FIRE, 10'h3FF, 24'd0);
    queue_op(tmh_pkg::OP_ADD, 10'd0, 24'd0);
    queue_op(tmh_pkg::OP_ADD, 10'h3FF, 24'hFF_FFFF);
    queue_op(tmh_pkg::OP_ADD, 10'd513, 24'd2);
    queue_op(tmh_pkg::OP_QUERY, 10'd0, 24'd0);
    queue_op(tmh_pkg::OP_ADD, 10'd513, 24'd5);
    queue_op(tmh_pkg::OP_ADJUST, 10'h3FF, 24'd1);
    queue_op(tmh_pkg::OP_TICK, 10'd0, 24'd0);
    queue_op(tmh_pkg::OP_TICK, 10'd0, 24'd0);
    queue_op(tmh_pkg::OP_FIRE, 10'd513, 24'd0);
    queue_op(tmh_pkg::OP_QUERY, 10'd0, 24'd0);
    queue_op(OP_UNUSED, 10'd1, 24'd1);
    queue_op(tmh_pkg::OP_CLEAR, 10'd0, 24'd0);
    queue_op(tmh_pkg::OP_QUERY, 10'd0, 24'd0);
    // fill the heap past capacity
    for (int i = 0; i < HEAP_DEPTH + 2; i++)
      queue_op(tmh_pkg::OP_ADD, 10'(i * 31), 24'(i % 5));
    queue_op(tmh_pkg::OP_QUERY, 10'd0, 24'd0);
    for (int i = 0; i < 6; i++) queue_op(tmh_pkg::OP_TICK, 10'd0, 24'd0);
    queue_op(OP_DRAIN_MARK, 10'd0, 24'd0);   // hold-off until all results are back
    queue_op(tmh_pkg::OP_CLEAR, 10'd0, 24'd0);

    // random: mostly adds and ticks on a small id pool, short timeouts
    for (int i = 0; i < 400; i++) begin
      op_pick = $urandom_range(0, 99);
      id_pick = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 47));
      kind = $urandom_range(0, 19);
      if (op_pick < 35)      queue_op(tmh_pkg::OP_ADD, id_pick,
                                 (kind == 0) ? 24'($urandom) : 24'($urandom_range(0, 12)));
      else if (op_pick < 45) queue_op(tmh_pkg::OP_ADJUST, id_pick,
                                      24'($urandom_range(0, 12)));
      else if (op_pick < 55) queue_op(tmh_pkg::OP_FIRE, id_pick, 24'($urandom));
      else if (op_pick < 85) queue_op(tmh_pkg::OP_TICK, 10'($urandom), 24'($urandom));
      else if (op_pick < 95) queue_op(tmh_pkg::OP_QUERY, 10'($urandom), 24'($urandom));
      else if (op_pick < 97) queue_op(tmh_pkg::OP_CLEAR, 10'($urandom), 24'($urandom));
      else                   queue_op(OP_UNUSED, id_pick, 24'($urandom));
      if (i == 200) queue_op(OP_DRAIN_MARK, 10'd0, 24'd0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() == 0 && !req.valid);
    wait (expected_rsps.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
